FILE: sv/salc_pkg.sv
// Shared types and command codes of the set-associative LRU cache tag controller.
`timescale 1ns / 1ps
package salc_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SHARE = 2'd2,
    CMD_INVAL = 2'd3
  } cmd_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_stall;
  } dp_status_t;

  localparam int unsigned OutTagBits = 50;
  localparam int unsigned OutBits = 56;

endpackage

FILE: sv/salc_ctrl.sv
// Controller state machine: clearing pass, transaction accept and commit sequencing.
`timescale 1ns / 1ps
module salc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  salc_pkg::dp_status_t   status_i,
  output salc_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;
  logic   ready_q;

  assign in_ready_o    = ready_q;
  assign cmd_o.clear   = (state_q == ST_CLEAR);
  assign cmd_o.accept  = (state_q == ST_IDLE) && ready_q && in_valid_i;
  assign cmd_o.commit  = (state_q == ST_LOOKUP) && !status_i.out_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ready_q <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_last) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (ready_q && in_valid_i) begin
            state_q <= ST_LOOKUP;
            ready_q <= 1'b0;
          end
        end
        ST_LOOKUP: begin
          // The result register must be free or draining before it is overwritten.
          if (!status_i.out_stall) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: sv/salc_dp.sv
// Datapath: tag and state memories, lookup, replacement, LRU update and result register.
`timescale 1ns / 1ps
module salc_dp #(
  parameter int unsigned WAYS        = 4,
  parameter int unsigned SETS        = 256,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned ADDR_BITS   = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  salc_pkg::ctrl_cmd_t           cmd_i,
  output salc_pkg::dp_status_t          status_o,
  input  logic [1:0]                    command_i,
  input  logic [63:0]                   address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [salc_pkg::OutBits-1:0]  out_data_o
);

  localparam int unsigned OB = $clog2(BLOCK_BYTES);
  localparam int unsigned IB = $clog2(SETS);
  localparam int TB = int'(ADDR_BITS) - int'(OB) - int'(IB);
  localparam int unsigned TW = (TB > 0) ? TB : 1;
  localparam int unsigned SW = (IB > 0) ? IB : 1;
  localparam int unsigned WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [63:0] TAG_KEEP = (TB <= 0) ? 64'd0 :
                                     ((TB >= 64) ? ~64'd0 : ((64'd1 << TB) - 64'd1));
  localparam logic [SW-1:0] SET_MASK = (IB == 0) ? '0 : '1;
  localparam logic [SW-1:0] SET_LAST = SW'(SETS - 1);

  // Memories: one row per set.
  logic [WAYS*TW-1:0] tag_mem   [SETS];
  logic [WAYS-1:0]    valid_mem [SETS];
  logic [WAYS-1:0]    dirty_mem [SETS];
  logic [WAYS-1:0]    shared_mem[SETS];
  logic [WAYS*WB-1:0] lru_mem   [SETS];

  logic [WAYS*TW-1:0] tag_rd_q;
  logic [WAYS-1:0]    valid_rd_q, dirty_rd_q, shared_rd_q;
  logic [WAYS*WB-1:0] lru_rd_q;

  logic [SW-1:0] clr_q;
  logic [SW-1:0] set_q;
  logic [TW-1:0] tag_q;
  logic [1:0]    cmd_q;

  logic [SW-1:0] set_in;
  logic [TW-1:0] tag_in;
  logic [63:0]   set_full, tag_full;

  assign set_full = address_i >> OB;
  assign tag_full = ((OB + IB) >= 64) ? 64'd0 : (address_i >> (OB + IB));
  assign set_in   = SW'(set_full) & SET_MASK;
  assign tag_in   = TW'(tag_full & TAG_KEEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + SW'(1);
    end
  end

  assign status_o.clear_last = cmd_i.clear && (clr_q == SET_LAST);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      set_q       <= set_in;
      tag_q       <= tag_in;
      cmd_q       <= command_i;
      tag_rd_q    <= tag_mem[set_in];
      valid_rd_q  <= valid_mem[set_in];
      dirty_rd_q  <= dirty_mem[set_in];
      shared_rd_q <= shared_mem[set_in];
      lru_rd_q    <= lru_mem[set_in];
    end
  end

  // Lookup and update of one set row.
  logic [WB-1:0]      ord     [WAYS];
  logic [WB-1:0]      ord_mru [WAYS];
  logic [WB-1:0]      ord_lru [WAYS];
  logic [WAYS*WB-1:0] lru_reset_row, lru_new;
  logic [TW-1:0]      way_tag [WAYS];
  logic               hit, has_free, is_rw, evict, evd, fill;
  logic [WB-1:0]      hit_way, free_way, lru_way, target, pos;
  logic [TW-1:0]      evtag;
  logic [WAYS-1:0]    valid_new, dirty_new, shared_new;
  logic [WAYS*TW-1:0] tag_new;
  logic [63:0]        way64, evtag64;
  logic [salc_pkg::OutBits-1:0] out_d;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      ord[i]      = lru_rd_q[i*WB +: WB];
      way_tag[i]  = tag_rd_q[i*TW +: TW];
      lru_reset_row[i*WB +: WB] = WB'(i);
    end

    hit     = 1'b0;
    hit_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (valid_rd_q[i] && (way_tag[i] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WB'(i);
      end
    end

    has_free = 1'b0;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!valid_rd_q[i]) begin
        has_free = 1'b1;
        free_way = WB'(i);
      end
    end

    lru_way = ord[0];
    is_rw   = (cmd_q == salc_pkg::CMD_READ) || (cmd_q == salc_pkg::CMD_WRITE);
    fill    = is_rw && !hit;
    evict   = fill && !has_free;

    if (hit)           target = hit_way;
    else if (!is_rw)   target = '0;
    else if (has_free) target = free_way;
    else               target = lru_way;

    evd   = evict && dirty_rd_q[lru_way];
    evtag = evict ? way_tag[lru_way] : '0;

    pos = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (ord[i] == target) pos = WB'(i);
    end

    // Recency order with the target moved to the most or the least recent place.
    for (int i = 0; i < WAYS - 1; i++) begin
      ord_mru[i] = (WB'(i) < pos) ? ord[i] : ord[i+1];
    end
    ord_mru[WAYS-1] = target;
    ord_lru[0] = target;
    for (int i = 1; i < WAYS; i++) begin
      ord_lru[i] = (WB'(i) <= pos) ? ord[i-1] : ord[i];
    end

    valid_new  = valid_rd_q;
    dirty_new  = dirty_rd_q;
    shared_new = shared_rd_q;
    tag_new    = tag_rd_q;
    lru_new    = lru_rd_q;

    if (is_rw) begin
      if (fill) begin
        tag_new[target*TW +: TW] = tag_q;
        valid_new[target]        = 1'b1;
        dirty_new[target]        = 1'b0;
        shared_new[target]       = 1'b0;
      end
      if (cmd_q == salc_pkg::CMD_WRITE) dirty_new[target] = 1'b1;
      for (int i = 0; i < WAYS; i++) lru_new[i*WB +: WB] = ord_mru[i];
    end else if (hit) begin
      if (cmd_q == salc_pkg::CMD_SHARE) begin
        shared_new[target] = 1'b1;
      end else begin
        valid_new[target] = 1'b0;
        for (int i = 0; i < WAYS; i++) lru_new[i*WB +: WB] = ord_lru[i];
      end
    end

    way64   = 64'(target);
    evtag64 = 64'(evtag);
    out_d   = {evtag64[salc_pkg::OutTagBits-1:0], evd, evict, !is_rw && !hit,
               way64[1:0], hit};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      valid_mem[clr_q]  <= '0;
      dirty_mem[clr_q]  <= '0;
      shared_mem[clr_q] <= '0;
      lru_mem[clr_q]    <= lru_reset_row;
    end else if (cmd_i.commit) begin
      valid_mem[set_q]  <= valid_new;
      dirty_mem[set_q]  <= dirty_new;
      shared_mem[set_q] <= shared_new;
      lru_mem[set_q]    <= lru_new;
      if (fill) tag_mem[set_q] <= tag_new;
    end
  end

  // Result register.
  logic                          out_valid_q;
  logic [salc_pkg::OutBits-1:0]  out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_data_q <= out_d;
  end

  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/set_assoc_lru_cache_tags.sv
// Sequence: an accepted transaction's set row is read into registers; the lookup state
// commits the row update and the result together once the result register is not
// stalled; a stalled result holds the input off, and nothing new is taken before commit.
// Reset: asynchronous; afterwards a clearing pass over every set initialises valid,
// dirty, shared and LRU rows, with s_axis_tready low throughout.
`timescale 1ns / 1ps
module set_assoc_lru_cache_tags #(
  parameter int unsigned WAYS        = 4,
  parameter int unsigned SETS        = 256,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned ADDR_BITS   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] address
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] hit, [2:1] way, [3] status, [4] evicted, [5] evicted_dirty, [55:6] evicted_tag
  output logic [55:0] m_axis_tdata
);

  salc_pkg::ctrl_cmd_t  cmd;
  salc_pkg::dp_status_t status;

  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  salc_dp #(
    .WAYS        (WAYS),
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .command_i   (s_axis_tuser),
    .address_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: verif/set_assoc_lru_cache_tags_tb.sv
// Self-checking testbench of the set-associative LRU cache tag controller.
`timescale 1ns / 1ps
module set_assoc_lru_cache_tags_tb;

  localparam int unsigned NWAYS = 4;
  localparam int unsigned NSETS = 256;

  typedef struct {
    salc_pkg::cmd_e cmd;
    logic [63:0]    addr;
  } access_t;

  typedef struct {
    logic        hit;
    logic [1:0]  way;
    logic        status;
    logic        evicted;
    logic        evicted_dirty;
    logic [49:0] evicted_tag;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = salc_pkg::CMD_READ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  set_assoc_lru_cache_tags dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the tag store; recency[s][0] is the least recently used way.
  logic [49:0] shadow_tag[NSETS][NWAYS];
  bit          shadow_valid[NSETS][NWAYS];
  bit          shadow_dirty[NSETS][NWAYS];
  bit          shadow_shared[NSETS][NWAYS];
  bit [1:0]    recency[NSETS][NWAYS];

  access_t  access_q[$];
  outcome_t outcome_q[$];
  int       fail_cnt = 0;
  int       rx_hold_cnt = 0;
  bit       rx_hold_req = 1'b0;
  bit       rx_hold_done = 1'b0;

  function automatic void reorder_way(int s, bit [1:0] w, int pos);
    bit [1:0] rest[NWAYS];
    int       n;
    int       k;
    n = 0;
    k = 0;
    for (int i = 0; i < NWAYS; i++) begin
      if (recency[s][i] != w) begin
        rest[n] = recency[s][i];
        n++;
      end
    end
    for (int i = 0; i < NWAYS; i++) begin
      if (i == pos) begin
        recency[s][i] = w;
      end else begin
        recency[s][i] = rest[k];
        k++;
      end
    end
  endfunction

  function automatic outcome_t lookup_and_update(salc_pkg::cmd_e cmd, logic [63:0] addr);
    outcome_t    r;
    int          s;
    logic [49:0] tg;
    bit          free;
    bit [1:0]    tgt;
    s    = int'(addr[13:6]);
    tg   = addr[63:14];
    free = 1'b0;
    tgt  = '0;
    r    = '{hit: 1'b0, way: '0, status: 1'b0, evicted: 1'b0, evicted_dirty: 1'b0,
             evicted_tag: '0};
    for (int w = NWAYS - 1; w >= 0; w--) begin
      if (!shadow_valid[s][w]) begin
        free = 1'b1;
        tgt  = 2'(w);
      end else if (shadow_tag[s][w] == tg) begin
        r.hit = 1'b1;
        tgt   = 2'(w);
        break;
      end
    end
    if (cmd == salc_pkg::CMD_READ || cmd == salc_pkg::CMD_WRITE) begin
      if (!r.hit) begin
        if (!free) begin
          tgt             = recency[s][0];
          r.evicted       = 1'b1;
          r.evicted_dirty = shadow_dirty[s][tgt];
          r.evicted_tag   = shadow_tag[s][tgt];
        end
        shadow_tag[s][tgt]    = tg;
        shadow_valid[s][tgt]  = 1'b1;
        shadow_dirty[s][tgt]  = 1'b0;
        shadow_shared[s][tgt] = 1'b0;
      end
      reorder_way(s, tgt, NWAYS - 1);
      if (cmd == salc_pkg::CMD_WRITE) shadow_dirty[s][tgt] = 1'b1;
    end else if (!r.hit) begin
      r.status = 1'b1;
      tgt      = '0;
    end else if (cmd == salc_pkg::CMD_SHARE) begin
      shadow_shared[s][tgt] = 1'b1;
    end else begin
      shadow_valid[s][tgt] = 1'b0;
      reorder_way(s, tgt, 0);
    end
    r.way = tgt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [49:0] exp, logic [49:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      fail_cnt++;
    end
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    access_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        outcome_q.push_back(lookup_and_update(salc_pkg::cmd_e'(s_axis_tuser), s_axis_tdata));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (access_q.size() > 0) begin
        nxt = access_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.addr;
        s_axis_tuser  <= nxt.cmd;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= int'($urandom_range(0, 20));
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down here once the stimulus requests it.
  always @(posedge clk_i) begin
    if (rx_hold_req && !rx_hold_done) begin
      rx_hold_cnt  <= 300;
      rx_hold_done <= 1'b1;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
    end
  end

  // Monitor: compares each result transaction and stalls on its own pattern.
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, m_axis_tdata);
          fail_cnt++;
        end else begin
          exp = outcome_q.pop_front();
          check_field("hit", 50'(exp.hit), 50'(m_axis_tdata[0]));
          check_field("way", 50'(exp.way), 50'(m_axis_tdata[2:1]));
          check_field("status", 50'(exp.status), 50'(m_axis_tdata[3]));
          check_field("evicted", 50'(exp.evicted), 50'(m_axis_tdata[4]));
          check_field("evicted_dirty", 50'(exp.evicted_dirty), 50'(m_axis_tdata[5]));
          check_field("evicted_tag", exp.evicted_tag, m_axis_tdata[55:6]);
        end
      end
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= int'($urandom_range(0, 2));
      if (rx_hold_cnt > 0) m_axis_tready <= 1'b0;
      else if (rx_mode == 0) m_axis_tready <= 1'b1;
      else if (rx_mode == 1) m_axis_tready <= (rx_cycle % 5) > 1;
      else m_axis_tready <= $urandom_range(0, 9) > 2;
    end
  end

  function automatic logic [63:0] make_addr(logic [49:0] tg, logic [7:0] s);
    return {tg, s, 6'($urandom)};
  endfunction

  task automatic add_access(salc_pkg::cmd_e cmd, logic [63:0] addr);
    access_t a;
    a.cmd  = cmd;
    a.addr = addr;
    access_q.push_back(a);
  endtask

  task automatic add_random(int n);
    int             pick;
    salc_pkg::cmd_e cmd;
    logic [7:0]     s;
    logic [49:0]    tg;
    logic [63:0]    wide;
    for (int i = 0; i < n; i++) begin
      pick = int'($urandom_range(0, 99));
      cmd  = pick < 40 ? salc_pkg::CMD_READ  : pick < 75 ? salc_pkg::CMD_WRITE :
             pick < 87 ? salc_pkg::CMD_SHARE : salc_pkg::CMD_INVAL;
      // Few sets and few tags per set so that hits and evictions are common.
      case ($urandom_range(0, 5))
        0: s = 8'd0;
        1: s = 8'd255;
        2, 3: s = 8'($urandom_range(1, 3));
        default: s = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: tg = '1;
        1: tg = 50'({$urandom, $urandom});
        default: tg = 50'($urandom_range(0, 6));
      endcase
      wide = {$urandom, $urandom};
      add_access(cmd, ($urandom_range(0, 19) == 0) ? wide : make_addr(tg, s));
    end
  endtask

  task automatic wait_drained();
    while (access_q.size() > 0 || s_axis_tvalid || outcome_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        shadow_valid[s][w]  = 1'b0;
        shadow_dirty[s][w]  = 1'b0;
        shadow_shared[s][w] = 1'b0;
        shadow_tag[s][w]    = '0;
        recency[s][w]       = 2'(w);
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: marks on an empty set, fills, hits, marks, refill and eviction.
    add_access(salc_pkg::CMD_SHARE, make_addr(50'd1, 8'd5));
    add_access(salc_pkg::CMD_INVAL, make_addr(50'd1, 8'd5));
    add_access(salc_pkg::CMD_READ,  make_addr(50'd1, 8'd5));
    add_access(salc_pkg::CMD_WRITE, make_addr(50'd2, 8'd5));
    add_access(salc_pkg::CMD_READ,  make_addr(50'd3, 8'd5));
    add_access(salc_pkg::CMD_WRITE, make_addr('1, 8'd5));
    add_access(salc_pkg::CMD_READ,  make_addr(50'd1, 8'd5));
    add_access(salc_pkg::CMD_SHARE, make_addr(50'd2, 8'd5));
    add_access(salc_pkg::CMD_INVAL, make_addr(50'd3, 8'd5));
    add_access(salc_pkg::CMD_READ,  make_addr(50'd4, 8'd5));
    add_access(salc_pkg::CMD_READ,  make_addr(50'd5, 8'd5));
    add_access(salc_pkg::CMD_WRITE, make_addr(50'd6, 8'd5));
    add_access(salc_pkg::CMD_READ,  make_addr(50'd7, 8'd5));
    add_access(salc_pkg::CMD_READ,  make_addr(50'd8, 8'd5));
    add_access(salc_pkg::CMD_READ,  64'd0);
    add_access(salc_pkg::CMD_WRITE, 64'd0);
    add_access(salc_pkg::CMD_READ,  '1);
    add_access(salc_pkg::CMD_WRITE, '1);
    add_access(salc_pkg::CMD_SHARE, '1);
    add_access(salc_pkg::CMD_INVAL, '1);
    add_access(salc_pkg::CMD_SHARE, '1);
    add_random(400);
    wait_drained();

    // Receiver holds off for a long stretch while the sender keeps offering.
    rx_hold_req = 1'b1;
    add_random(600);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
